[rtl/wavp_pkg.sv]
`default_nettype none

package wavp_pkg;

   // Four-character codes as they assemble little endian
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] TAG_FACT = 32'h7463_6166;

   localparam logic [15:0] FORMAT_PCM  = 16'd1;
   localparam logic [31:0] FMT_MIN_LEN = 32'd16;
   localparam int          FMT_BYTES   = 16;

   // Parser phase, one-hot
   typedef enum logic [8:0] {
      PH_RIFF  = 9'b0_0000_0001,
      PH_RSIZE = 9'b0_0000_0010,
      PH_WAVE  = 9'b0_0000_0100,
      PH_HDR   = 9'b0_0000_1000,
      PH_SKIP  = 9'b0_0001_0000,
      PH_FMT   = 9'b0_0010_0000,
      PH_POST  = 9'b0_0100_0000,
      PH_FACT  = 9'b0_1000_0000,
      PH_DONE  = 9'b1_0000_0000
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_RIFF  = 3'd1,
      ST_NOT_WAVE  = 3'd2,
      ST_FMT_SMALL = 3'd3,
      ST_NOT_PCM   = 3'd4,
      ST_BAD_CHUNK = 3'd5,
      ST_TRUNC     = 3'd6
   } status_type;

   // One parse result
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] data_offset;
      logic [31:0] data_size;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
   } result_type;

endpackage

`default_nettype wire

[rtl/wavp_core.sv]
`default_nettype none

module wavp_core
   import wavp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,       // one byte is consumed this cycle
   input  wire logic [7:0] file_byte,
   input  wire logic       end_of_file,
   output logic            emit,       // a result is produced by this byte
   output result_type      result
);

   phase_type   phase_ff, phase_in, ph_mid;
   logic [31:0] cnt_ff, cnt_in, cnt_inc;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [7:0]  fmt_ff  [FMT_BYTES];
   logic [7:0]  fmt_nxt [FMT_BYTES];
   logic        fmt_we;
   logic        verdict;
   status_type  vstat;
   logic        fmt_seen;

   assign cnt_inc = cnt_ff + 32'd1;

   // Per-byte parse step
   always_comb begin
      ph_mid  = phase_ff;
      cnt_in  = cnt_ff;
      tag_in  = tag_ff;
      len_in  = len_ff;
      fmt_we  = 1'b0;
      verdict = 1'b0;
      vstat   = ST_OK;
      unique case (phase_ff)
         PH_RIFF, PH_RSIZE, PH_WAVE: begin
            tag_in = {file_byte, tag_ff[31:8]};
            cnt_in = cnt_inc;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in = '0;
               if (phase_ff == PH_RIFF && tag_in != TAG_RIFF) begin
                  verdict = 1'b1;
                  vstat   = ST_NOT_RIFF;
               end else if (phase_ff == PH_WAVE && tag_in != TAG_WAVE) begin
                  verdict = 1'b1;
                  vstat   = ST_NOT_WAVE;
               end else if (phase_ff == PH_RIFF) begin
                  ph_mid = PH_RSIZE;
               end else if (phase_ff == PH_RSIZE) begin
                  ph_mid = PH_WAVE;
               end else begin
                  ph_mid = PH_HDR;
               end
            end
         end
         PH_HDR, PH_POST: begin
            if (!cnt_ff[2]) begin
               tag_in = {file_byte, tag_ff[31:8]};
            end else begin
               len_in = {file_byte, len_ff[31:8]};
            end
            cnt_in = cnt_inc;
            if (cnt_ff[2:0] == 3'd7) begin
               cnt_in = '0;
               if (phase_ff == PH_HDR) begin
                  if (tag_in == TAG_FMT) begin
                     if (len_in < FMT_MIN_LEN) begin
                        verdict = 1'b1;
                        vstat   = ST_FMT_SMALL;
                     end else begin
                        ph_mid = PH_FMT;
                     end
                  end else if (len_in != '0) begin
                     ph_mid = PH_SKIP;
                  end
               end else if (tag_in == TAG_DATA) begin
                  verdict = 1'b1;
                  vstat   = ST_OK;
               end else if (tag_in == TAG_FACT) begin
                  ph_mid = PH_FACT;
               end else begin
                  verdict = 1'b1;
                  vstat   = ST_BAD_CHUNK;
               end
            end
         end
         PH_SKIP: begin
            cnt_in = cnt_inc;
            if (cnt_inc == len_ff) begin
               cnt_in = '0;
               ph_mid = PH_HDR;
            end
         end
         PH_FMT: begin
            fmt_we = (cnt_ff[31:4] == '0);
            cnt_in = cnt_inc;
            if (cnt_inc == len_ff) begin
               cnt_in = '0;
               ph_mid = PH_POST;
               if ({fmt_nxt[1], fmt_nxt[0]} != FORMAT_PCM) begin
                  verdict = 1'b1;
                  vstat   = ST_NOT_PCM;
               end
            end
         end
         PH_FACT: begin
            cnt_in = cnt_inc;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in = '0;
               ph_mid = PH_POST;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Format bytes including the one written this cycle
   always_comb begin
      for (int i = 0; i < FMT_BYTES; i++) begin
         fmt_nxt[i] = fmt_ff[i];
      end
      if (fmt_we) begin
         fmt_nxt[cnt_ff[3:0]] = file_byte;
      end
   end

   // Verdict or truncation, and the result fields
   assign emit     = verdict || (end_of_file && phase_ff != PH_DONE);
   assign fmt_seen = (ph_mid == PH_POST) || (ph_mid == PH_FACT);

   always_comb begin
      result.status          = verdict ? vstat : ST_TRUNC;
      result.data_offset     = (verdict && vstat == ST_OK) ? pos_ff + 32'd1 : '0;
      result.data_size       = (verdict && vstat == ST_OK) ? len_in : '0;
      result.channel_count   = '0;
      result.sample_rate     = '0;
      result.byte_rate       = '0;
      result.block_align     = '0;
      result.bits_per_sample = '0;
      if (fmt_seen) begin
         result.channel_count   = {fmt_nxt[3], fmt_nxt[2]};
         result.sample_rate     = {fmt_nxt[7], fmt_nxt[6], fmt_nxt[5], fmt_nxt[4]};
         result.byte_rate       = {fmt_nxt[11], fmt_nxt[10], fmt_nxt[9], fmt_nxt[8]};
         result.block_align     = {fmt_nxt[13], fmt_nxt[12]};
         result.bits_per_sample = {fmt_nxt[15], fmt_nxt[14]};
      end
   end

   // Next control state; the last byte of a file rearms
   always_comb begin
      if (end_of_file) begin
         phase_in = PH_RIFF;
         pos_in   = '0;
      end else begin
         phase_in = verdict ? PH_DONE : ph_mid;
         pos_in   = pos_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         cnt_ff   <= '0;
         pos_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= end_of_file ? '0 : cnt_in;
         pos_ff   <= pos_in;
      end
   end

   // Payload: tag, length and format bytes
   always_ff @(posedge clock) begin
      if (step) begin
         tag_ff <= tag_in;
         len_ff <= len_in;
         for (int i = 0; i < FMT_BYTES; i++) begin
            fmt_ff[i] <= fmt_nxt[i];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/riff_wave_header_parser.sv]
// RIFF/WAVE header parser.
// req channel: one file byte per transaction in file order (req_tdata), with
// req_tlast on the final byte of the file. rsp channel: one transaction per
// file carrying the status in rsp_tuser and the data chunk position and PCM
// format fields in rsp_tdata. A file whose last byte comes before a verdict
// gets a truncated status; bytes after a verdict are dropped up to tlast.
// Throughput: one byte per clock while the result register does not stay full
// with rsp_tready low. Each byte passes an input register, then the parse step
// and the result register, so the result of the byte that decides it shows on
// rsp_tvalid from the result register. The parse state updates once per byte,
// which sets the rate at one byte per clock when nothing stalls.
// While a result waits in the output register with rsp_tready low, one more
// byte can be held in the input register; the parser stalls only when that
// byte is ready to advance and the output register is still full.
// Reset (synchronous, active high) empties both registers and returns the
// parser to expect the RIFF tag of a new file.
`default_nettype none

module riff_wave_header_parser
   import wavp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] file_byte
   input  wire logic         req_tlast,   // end_of_file
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [175:0]      rsp_tdata,   // [31:0] data_offset, [63:32] data_size,
                                          // [79:64] channel_count, [111:80] sample_rate,
                                          // [143:112] byte_rate, [159:144] block_align,
                                          // [175:160] bits_per_sample
   output logic [2:0]        rsp_tuser    // [2:0] status
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       core_step;
   logic       core_emit;
   result_type core_result;

   // Advance the held byte when the result slot is free or drains now
   assign core_step  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || core_step;

   wavp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (core_step),
      .file_byte   (in_byte_ff),
      .end_of_file (in_eof_ff),
      .emit        (core_emit),
      .result      (core_result)
   );

   // Input register
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 :
                        (core_step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eof_ff  <= req_tlast;
      end
   end

   // Result register
   assign out_valid_in = (core_step && core_emit) ? 1'b1 :
                         (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_step && core_emit) begin
         out_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {out_ff.bits_per_sample, out_ff.block_align, out_ff.byte_rate,
                        out_ff.sample_rate, out_ff.channel_count, out_ff.data_size,
                        out_ff.data_offset};

endmodule

`default_nettype wire

[rtl/wavp_checker.sv]
`default_nettype none

module wavp_checker
   import wavp_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [175:0] rsp_tdata,
   input wire logic [2:0]   rsp_tuser
);

   // A stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No status code beyond truncated
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 3'd7)
      else $error("undefined status code");

   // Data chunk position only reported on success
   a_data_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[63:0] == 64'd0)
      else $error("data position on a failed parse");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind riff_wave_header_parser wavp_checker u_wavp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[test/riff_wave_header_parser_tb.sv]
`timescale 1ns / 1ps

module riff_wave_header_parser_tb;
   import wavp_pkg::*;

   // Tracks the parser state byte by byte and holds the verdicts still owed
   class wave_header_scoreboard_type;
      phase_type   phase;
      logic [31:0] field_count;
      logic [31:0] shift_word;
      logic [31:0] tag;
      logic [31:0] length;
      logic [31:0] position;
      logic [127:0] fmt_store;
      bit          decided;
      result_type  pending_verdicts[$];
      int          errors;
      int          status_hits[8];

      function new();
         errors = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
         restart();
      endfunction

      function void restart();
         phase       = PH_RIFF;
         field_count = '0;
         shift_word  = '0;
         tag         = '0;
         length      = '0;
         position    = '0;
         fmt_store   = '0;
         decided     = 1'b0;
      endfunction

      // Format fields only count once the whole fmt body is in
      function result_type verdict_of(status_type st);
         result_type  r;
         logic [127:0] w;
         w = (phase == PH_POST || phase == PH_FACT) ? fmt_store : '0;
         r.status          = st;
         r.data_offset     = (st == ST_OK) ? position + 32'd1 : '0;
         r.data_size       = (st == ST_OK) ? length : '0;
         r.channel_count   = w[31:16];
         r.sample_rate     = w[63:32];
         r.byte_rate       = w[95:64];
         r.block_align     = w[111:96];
         r.bits_per_sample = w[127:112];
         return r;
      endfunction

      // One accepted req transaction
      function void note_byte(logic [7:0] b, logic last);
         status_type verdict;
         bit         judged;
         bit         hdr_done;
         verdict  = ST_OK;
         judged   = 1'b0;
         hdr_done = 1'b0;
         if (!decided) begin
            // chunk header: tag then size, both little endian
            if (phase == PH_HDR || phase == PH_POST) begin
               if (field_count < 4) tag = {b, tag[31:8]};
               else length = {b, length[31:8]};
               field_count++;
               if (field_count == 8) begin
                  field_count = '0;
                  hdr_done    = 1'b1;
               end
            end
            case (phase)
               PH_RIFF, PH_RSIZE, PH_WAVE: begin
                  shift_word = {b, shift_word[31:8]};
                  field_count++;
                  if (field_count == 4) begin
                     field_count = '0;
                     if (phase == PH_RIFF && shift_word != TAG_RIFF) begin
                        verdict = ST_NOT_RIFF;
                        judged  = 1'b1;
                     end else if (phase == PH_WAVE && shift_word != TAG_WAVE) begin
                        verdict = ST_NOT_WAVE;
                        judged  = 1'b1;
                     end else begin
                        phase = (phase == PH_RIFF) ? PH_RSIZE :
                                (phase == PH_RSIZE) ? PH_WAVE : PH_HDR;
                     end
                  end
               end
               PH_HDR: begin
                  if (hdr_done) begin
                     if (tag == TAG_FMT) begin
                        if (length < FMT_MIN_LEN) begin
                           verdict = ST_FMT_SMALL;
                           judged  = 1'b1;
                        end else begin
                           phase = PH_FMT;
                        end
                     end else if (length != 0) begin
                        phase = PH_SKIP;
                     end
                  end
               end
               PH_SKIP: begin
                  field_count++;
                  if (field_count == length) begin
                     field_count = '0;
                     phase       = PH_HDR;
                  end
               end
               PH_FMT: begin
                  if (field_count < FMT_MIN_LEN)
                     fmt_store[field_count[3:0]*8 +: 8] |= b;
                  field_count++;
                  if (field_count == length) begin
                     field_count = '0;
                     phase       = PH_POST;
                     if (fmt_store[15:0] != FORMAT_PCM) begin
                        verdict = ST_NOT_PCM;
                        judged  = 1'b1;
                     end
                  end
               end
               PH_POST: begin
                  if (hdr_done) begin
                     if (tag == TAG_DATA) begin
                        verdict = ST_OK;
                        judged  = 1'b1;
                     end else if (tag == TAG_FACT) begin
                        phase = PH_FACT;
                     end else begin
                        verdict = ST_BAD_CHUNK;
                        judged  = 1'b1;
                     end
                  end
               end
               PH_FACT: begin
                  field_count++;
                  if (field_count == 4) begin
                     field_count = '0;
                     phase       = PH_POST;
                  end
               end
               default: ;
            endcase
            if (judged) begin
               pending_verdicts.push_back(verdict_of(verdict));
               decided = 1'b1;
            end
         end
         // end of file rearms; a file cut short gets a truncated verdict
         if (last) begin
            if (!decided) pending_verdicts.push_back(verdict_of(ST_TRUNC));
            restart();
         end else begin
            position++;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
            errors++;
         end
      endfunction

      // One accepted rsp transaction
      function void check_verdict(logic [2:0] st, logic [175:0] d);
         result_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d data %h",
                     $time, st, d);
            errors++;
            return;
         end
         want = pending_verdicts.pop_front();
         status_hits[want.status]++;
         compare_field("status", want.status, st);
         compare_field("data_offset", want.data_offset, d[31:0]);
         compare_field("data_size", want.data_size, d[63:32]);
         compare_field("channel_count", want.channel_count, d[79:64]);
         compare_field("sample_rate", want.sample_rate, d[111:80]);
         compare_field("byte_rate", want.byte_rate, d[143:112]);
         compare_field("block_align", want.block_align, d[159:144]);
         compare_field("bits_per_sample", want.bits_per_sample, d[175:160]);
      endfunction
   endclass

   // Shape of one generated file
   typedef struct {
      logic [31:0] riff_tag;
      logic [31:0] wave_tag;
      logic [31:0] last_tag;
      logic [31:0] fmt_len;
      logic [31:0] data_size;
      logic [31:0] rate;
      logic [31:0] brate;
      logic [31:0] pre_tag_a;
      logic [31:0] pre_tag_b;
      logic [15:0] fmt_tag;
      logic [15:0] channels;
      logic [15:0] align;
      logic [15:0] bits;
      int          n_pre;
      int          pre_len_a;
      int          pre_len_b;
      int          n_fact;
      int          trailing;
      int          cut;        // 0 whole file, -1 random cut, else bytes kept
      int          noise_len;  // nonzero: random bytes only
   } wave_plan_type;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic [7:0]   req_tdata  = '0;
   logic         req_tlast  = 1'b0;
   logic         rsp_tready = 1'b0;
   logic         req_tready;
   logic         rsp_tvalid;
   logic [175:0] rsp_tdata;
   logic [2:0]   rsp_tuser;

   wave_header_scoreboard_type sb = new();
   logic [7:0] file_bytes[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent    = 0;
   int files_sent    = 0;

   riff_wave_header_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result side: random backpressure, check every rsp transaction
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_verdict(rsp_tuser, rsp_tdata);
   end

   function automatic void put_le(logic [31:0] v, int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic logic [31:0] pick_skip_tag();
      logic [31:0] t;
      case ($urandom_range(3))
         0: t = TAG_DATA;
         1: t = TAG_FACT;
         2: t = TAG_WAVE;
         default: begin
            t = $urandom;
            if (t == TAG_FMT) t ^= 32'h1;
         end
      endcase
      return t;
   endfunction

   // A well-formed file with random content
   function automatic wave_plan_type base_plan();
      wave_plan_type p;
      p.riff_tag  = TAG_RIFF;
      p.wave_tag  = TAG_WAVE;
      p.last_tag  = TAG_DATA;
      p.n_pre     = $urandom_range(0, 2);
      p.pre_tag_a = pick_skip_tag();
      p.pre_tag_b = pick_skip_tag();
      p.pre_len_a = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 9);
      p.pre_len_b = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 9);
      p.fmt_len   = ($urandom_range(3) == 0) ? 16 + $urandom_range(1, 8) : 16;
      p.fmt_tag   = FORMAT_PCM;
      p.channels  = 16'($urandom);
      p.rate      = $urandom;
      p.brate     = $urandom;
      p.align     = 16'($urandom);
      p.bits      = 16'($urandom);
      p.n_fact    = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
      p.data_size = $urandom;
      p.trailing  = $urandom_range(0, 5);
      p.cut       = 0;
      p.noise_len = 0;
      return p;
   endfunction

   // Good files in just under half of the picks, the rest broken in one place or plain noise
   function automatic wave_plan_type random_plan();
      wave_plan_type p;
      int            pick;
      p    = base_plan();
      pick = $urandom_range(99);
      if (pick < 6) begin
         p.riff_tag = TAG_RIFF ^ (32'h1 << $urandom_range(31));
      end else if (pick < 12) begin
         p.wave_tag = TAG_WAVE ^ (32'h1 << $urandom_range(31));
      end else if (pick < 20) begin
         p.fmt_len = $urandom_range(0, 15);
      end else if (pick < 28) begin
         p.fmt_tag = 16'($urandom);
         if (p.fmt_tag == FORMAT_PCM) p.fmt_tag ^= 16'h8000;
      end else if (pick < 36) begin
         case ($urandom_range(2))
            0: p.last_tag = TAG_FMT;
            1: p.last_tag = TAG_RIFF;
            default: begin
               p.last_tag = $urandom;
               if (p.last_tag == TAG_DATA || p.last_tag == TAG_FACT) p.last_tag ^= 32'h1;
            end
         endcase
      end else if (pick < 47) begin
         p.cut = -1;
      end else if (pick < 51) begin
         p.noise_len = $urandom_range(1, 30);
      end
      return p;
   endfunction

   function automatic void build_file(wave_plan_type p);
      logic [127:0] fmt_body;
      int           keep;
      file_bytes.delete();
      if (p.noise_len > 0) begin
         repeat (p.noise_len) file_bytes.push_back(8'($urandom));
         return;
      end
      fmt_body = {p.bits, p.align, p.brate, p.rate, p.channels, p.fmt_tag};
      put_le(p.riff_tag, 4);
      put_le($urandom, 4);
      put_le(p.wave_tag, 4);
      for (int i = 0; i < p.n_pre; i++) begin
         put_le((i == 0) ? p.pre_tag_a : p.pre_tag_b, 4);
         put_le((i == 0) ? p.pre_len_a : p.pre_len_b, 4);
         repeat ((i == 0) ? p.pre_len_a : p.pre_len_b) file_bytes.push_back(8'($urandom));
      end
      put_le(TAG_FMT, 4);
      put_le(p.fmt_len, 4);
      for (int k = 0; k < p.fmt_len; k++)
         file_bytes.push_back((k < 16) ? fmt_body[8*k +: 8] : 8'($urandom));
      for (int f = 0; f < p.n_fact; f++) begin
         put_le(TAG_FACT, 4);
         put_le($urandom, 4);
         put_le($urandom, 4);
      end
      put_le(p.last_tag, 4);
      put_le(p.data_size, 4);
      if (p.cut != 0) begin
         keep = (p.cut > 0) ? p.cut : $urandom_range(1, file_bytes.size() - 1);
         while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end else begin
         repeat (p.trailing) file_bytes.push_back(8'($urandom));
      end
   endfunction

   // Entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      bytes_sent += file_bytes.size();
      files_sent++;
   endtask

   initial begin
      wave_plan_type p;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 27;
      recv_idle_pct = 77;

      // Directed files: field extremes, every verdict, the corner cases
      for (int d = 0; d < 19; d++) begin
         p          = base_plan();
         p.n_pre    = 0;
         p.n_fact   = 0;
         p.trailing = 0;
         p.fmt_len  = 16;
         case (d)
            1: begin
               p.channels  = '1;
               p.rate      = '1;
               p.brate     = '1;
               p.align     = '1;
               p.bits      = '1;
               p.data_size = '1;
            end
            2: begin
               p.channels  = '0;
               p.rate      = '0;
               p.brate     = '0;
               p.align     = '0;
               p.bits      = '0;
               p.data_size = '0;
            end
            3: p.riff_tag = TAG_RIFF ^ 32'h0000_0001;
            4: begin
               // only the fourth tag byte is wrong
               p.riff_tag = TAG_RIFF ^ 32'h1000_0000;
               p.trailing = 3;
            end
            5: p.wave_tag = TAG_WAVE ^ 32'h8000_0000;
            6: p.fmt_len = 15;
            7: p.fmt_len = 0;
            8: p.fmt_tag = 16'h0000;
            9: p.fmt_tag = 16'hFFFF;
            10: p.last_tag = TAG_FMT;
            11: p.n_fact = 2;
            12: begin
               p.n_pre     = 1;
               p.pre_len_a = 0;
            end
            13: begin
               p.n_pre     = 2;
               p.pre_len_a = 3;
               p.pre_len_b = 1;
            end
            14: p.fmt_len = 24;
            15: p.noise_len = 1;
            16: p.cut = 43;
            17: p.trailing = 6;
            18: begin
               // a data chunk before fmt is just skipped
               p.n_pre     = 1;
               p.pre_tag_a = TAG_DATA;
               p.pre_len_a = 5;
            end
            default: ;
         endcase
         build_file(p);
         send_file();
      end

      // Random files under three handshake pressure mixes
      while (bytes_sent < 2000) begin
         if (bytes_sent >= 1400) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (bytes_sent >= 700) begin
            send_idle_pct = 77;
            recv_idle_pct = 27;
         end
         build_file(random_plan());
         send_file();
      end
      req_tvalid <= 1'b0;

      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d files in %0d bytes; verdicts ok %0d, not riff %0d, not wave %0d,",
               files_sent, bytes_sent, sb.status_hits[ST_OK], sb.status_hits[ST_NOT_RIFF],
               sb.status_hits[ST_NOT_WAVE]);
      $display("fmt small %0d, not pcm %0d, bad chunk %0d, truncated %0d; %0d mismatches",
               sb.status_hits[ST_FMT_SMALL], sb.status_hits[ST_NOT_PCM],
               sb.status_hits[ST_BAD_CHUNK], sb.status_hits[ST_TRUNC], sb.errors);
      if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
         $display("riff_wave_header_parser_tb passed");
      end else begin
         $display("riff_wave_header_parser_tb failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(10_000_000);
      $display("%0t: timeout with %0d results outstanding", $time,
               sb.pending_verdicts.size());
      $display("riff_wave_header_parser_tb failed");
      $finish;
   end

endmodule
